FILE: src/etfi_pkg.sv
// ----------------------------------------------------------------------------
// etfi_pkg: shared definitions for the escape-time fractal iterator
// Widths, fixed-point constants, register indexes and the command and status
// types that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package etfi_pkg;

    localparam int DATA_W     = 48;
    localparam int EXT_W      = DATA_W + 2;
    localparam int IN_W       = 32;
    localparam int CNT_W      = 15;
    localparam int MODE_W     = 2;
    localparam int GAIN_W     = 16;
    localparam int CFG_W      = 16;
    localparam int IDX_W      = 2;

    localparam int FRAC_BITS  = 24;
    localparam int INT_FRAC   = 10;
    localparam int GAIN_FRAC  = 10;
    localparam int ITER_LIMIT = 16384;

    localparam logic [MODE_W-1:0] MODE_QUAD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUARTIC = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INT     = 2'd2;

    localparam logic [IDX_W-1:0] REG_MODE  = 2'd0;
    localparam logic [IDX_W-1:0] REG_MAXIT = 2'd1;
    localparam logic [IDX_W-1:0] REG_GAIN  = 2'd2;

    localparam logic [MODE_W-1:0] MODE_RESET  = MODE_QUAD;
    localparam logic [CNT_W-1:0]  MAXIT_RESET = 15'd1024;
    localparam logic [GAIN_W-1:0] GAIN_RESET  = 16'd2048;

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    localparam logic signed [DATA_W-1:0] BAIL_QUAD    = DATA_W'(16) << FRAC_BITS;
    localparam logic signed [DATA_W-1:0] BAIL_QUARTIC = DATA_W'(40) << FRAC_BITS;
    localparam logic signed [DATA_W-1:0] BAIL_INT     = DATA_W'(16) << INT_FRAC;

    // Destination of a multiplier result; also names the operand pair.
    typedef enum logic [1:0] {
        DST_X2,
        DST_Y2,
        DST_T,
        DST_TG
    } dest_t;

    typedef enum logic [1:0] {
        SH_FRAC,
        SH_GAIN,
        SH_NONE
    } shift_t;

    typedef struct packed {
        shift_t sh;
        logic   post;
        dest_t  dst;
    } mul_ctl_t;

    typedef struct packed {
        logic  load;
        logic  mul_issue;
        dest_t mul_dst;
        logic  diff;
        logic  fx_prep;
        logic  fx_write;
        logic  fy_write;
        logic  add_c;
        logic  count_inc;
    } cmd_t;

    typedef struct packed {
        logic go;
    } status_t;

endpackage

FILE: src/etfi_mul.sv
// ----------------------------------------------------------------------------
// etfi_mul: pipelined signed fixed-point multiplier
// Registered magnitudes, 24x24 partial products and sum, then a combinational
// shift, saturate and sign restore. Accepts one operation per cycle.
// ----------------------------------------------------------------------------
module etfi_mul (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              issue,
    input  logic signed [etfi_pkg::DATA_W-1:0] op_a,
    input  logic signed [etfi_pkg::DATA_W-1:0] op_b,
    input  etfi_pkg::mul_ctl_t                ctl_in,
    output logic                              res_valid,
    output etfi_pkg::dest_t                   res_dst,
    output logic signed [etfi_pkg::DATA_W-1:0] res
);
    import etfi_pkg::*;

    localparam int H_W = DATA_W / 2;
    localparam int P_W = 2 * H_W;
    localparam int S_W = 2 * DATA_W;

    logic [DATA_W-1:0] ua;
    logic [DATA_W-1:0] ub;
    logic [DATA_W-1:0] ma_next;
    logic [DATA_W-1:0] mb_next;

    logic              v0_reg, v1_reg, v2_reg;
    logic              neg0_reg, neg1_reg, neg2_reg;
    mul_ctl_t          ctl0_reg, ctl1_reg, ctl2_reg;
    logic [DATA_W-1:0] ma_reg;
    logic [DATA_W-1:0] mb_reg;
    logic [P_W-1:0]    p00_reg, p01_reg, p10_reg, p11_reg;
    logic [S_W-1:0]    sum_reg;
    logic [P_W:0]      mid;

    logic [S_W-1:0]    shifted;
    logic [S_W-1:0]    lim;
    logic [DATA_W-1:0] mag;
    logic [DATA_W-1:0] mag_post;

    always_comb
    begin
        ua      = op_a;
        ub      = op_b;
        ma_next = ua[DATA_W-1] ? (~ua + DATA_W'(1)) : ua;
        mb_next = ub[DATA_W-1] ? (~ub + DATA_W'(1)) : ub;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= issue;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        neg0_reg <= op_a[DATA_W-1] ^ op_b[DATA_W-1];
        ctl0_reg <= ctl_in;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;

        neg1_reg <= neg0_reg;
        ctl1_reg <= ctl0_reg;
        p00_reg  <= P_W'(ma_reg[H_W-1:0])      * P_W'(mb_reg[H_W-1:0]);
        p01_reg  <= P_W'(ma_reg[H_W-1:0])      * P_W'(mb_reg[DATA_W-1:H_W]);
        p10_reg  <= P_W'(ma_reg[DATA_W-1:H_W]) * P_W'(mb_reg[H_W-1:0]);
        p11_reg  <= P_W'(ma_reg[DATA_W-1:H_W]) * P_W'(mb_reg[DATA_W-1:H_W]);

        neg2_reg <= neg1_reg;
        ctl2_reg <= ctl1_reg;
        sum_reg  <= {p11_reg, p00_reg} + (S_W'(mid) << H_W);
    end

    assign mid = (P_W + 1)'(p01_reg) + (P_W + 1)'(p10_reg);

    always_comb
    begin
        case (ctl2_reg.sh)
            SH_FRAC: shifted = sum_reg >> FRAC_BITS;
            SH_GAIN: shifted = sum_reg >> GAIN_FRAC;
            SH_NONE: shifted = sum_reg;
            default: shifted = sum_reg;
        endcase
        // A negative result may reach one step further than a positive one.
        lim = neg2_reg ? (S_W'(1) << (DATA_W - 1)) : S_W'(SAT_MAX);
        mag = (shifted > lim) ? lim[DATA_W-1:0] : shifted[DATA_W-1:0];
        // Truncation toward zero after saturation acts on the magnitude.
        mag_post = ctl2_reg.post ? (mag >> INT_FRAC) : mag;
        res = neg2_reg ? $signed(~mag_post + DATA_W'(1)) : $signed(mag_post);
    end

    assign res_valid = v2_reg;
    assign res_dst   = ctl2_reg.dst;

endmodule

FILE: src/etfi_datapath.sv
// ----------------------------------------------------------------------------
// etfi_datapath: iteration datapath of the escape-time fractal iterator
// Holds z, c, the squared magnitude and the count, and runs the shared
// multiplier and the saturating adders under the controller's commands.
// ----------------------------------------------------------------------------
module etfi_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  etfi_pkg::cmd_t                     cmd,
    output etfi_pkg::status_t                  status,
    input  logic [etfi_pkg::MODE_W-1:0]        mode,
    input  logic [etfi_pkg::CNT_W-1:0]         max_iterations,
    input  logic [etfi_pkg::GAIN_W-1:0]        cross_gain,
    input  logic signed [etfi_pkg::IN_W-1:0]   c_real,
    input  logic signed [etfi_pkg::IN_W-1:0]   c_imag,
    output logic [etfi_pkg::CNT_W-1:0]         iteration_count
);
    import etfi_pkg::*;

    localparam int L_W      = IN_W + 2;
    localparam int IN_SHIFT = FRAC_BITS - INT_FRAC;
    localparam logic signed [L_W-1:0] OFFSET  = L_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [L_W-1:0] IN_BIAS = (L_W'(1) << IN_SHIFT) - L_W'(1);
    localparam logic signed [DATA_W-1:0] TZ_BIAS = (DATA_W'(1) << INT_FRAC) - DATA_W'(1);

    function automatic logic signed [DATA_W-1:0] sat_ext(input logic signed [EXT_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > EXT_W'(SAT_MAX))
            r = SAT_MAX;
        else if (v < EXT_W'(SAT_MIN))
            r = SAT_MIN;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

    // Divide by 2^INT_FRAC, truncating toward zero.
    function automatic logic signed [DATA_W-1:0] tz_frac(input logic signed [DATA_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        r = (v + (v[DATA_W-1] ? TZ_BIAS : DATA_W'(0))) >>> INT_FRAC;
        return r;
    endfunction

    logic                     intmode;
    logic                     quartic;
    logic signed [DATA_W-1:0] bail;
    logic [CNT_W-1:0]         lim;

    logic signed [L_W-1:0]    cr_ext;
    logic signed [L_W-1:0]    ci_ext;
    logic signed [L_W-1:0]    cr_off;
    logic signed [L_W-1:0]    a_load;
    logic signed [L_W-1:0]    b_load;

    logic signed [DATA_W-1:0] a_reg, b_reg;
    logic signed [DATA_W-1:0] fx_reg, fy_reg, fd_reg;
    logic signed [DATA_W-1:0] x2_reg, y2_reg, t_reg, tg_reg;
    logic signed [EXT_W-1:0]  diff_reg;
    logic signed [DATA_W-1:0] sum_reg;
    logic signed [EXT_W-1:0]  ein_reg;
    logic [CNT_W-1:0]         count_reg;

    logic signed [DATA_W-1:0] op_a, op_b;
    mul_ctl_t                 mul_ctl;
    logic                     res_valid;
    dest_t                    res_dst;
    logic signed [DATA_W-1:0] res;

    assign intmode = (mode == MODE_INT);
    assign quartic = (mode == MODE_QUARTIC);

    always_comb
    begin
        if (intmode)
            bail = BAIL_INT;
        else if (quartic)
            bail = BAIL_QUARTIC;
        else
            bail = BAIL_QUAD;
        lim = (int'(max_iterations) > ITER_LIMIT) ? CNT_W'(ITER_LIMIT) : max_iterations;
    end

    always_comb
    begin
        cr_ext = L_W'(c_real);
        ci_ext = L_W'(c_imag);
        cr_off = quartic ? cr_ext : (cr_ext - OFFSET);
        if (intmode)
        begin
            a_load = (cr_off + (cr_off[L_W-1] ? IN_BIAS : L_W'(0))) >>> IN_SHIFT;
            b_load = (ci_ext + (ci_ext[L_W-1] ? IN_BIAS : L_W'(0))) >>> IN_SHIFT;
        end
        else
        begin
            a_load = cr_off;
            b_load = ci_ext;
        end
    end

    always_comb
    begin
        case (cmd.mul_dst)
            DST_X2:
            begin
                op_a = fx_reg;
                op_b = fx_reg;
            end
            DST_Y2:
            begin
                op_a = fy_reg;
                op_b = fy_reg;
            end
            DST_T:
            begin
                op_a = fx_reg;
                op_b = fy_reg;
            end
            DST_TG:
            begin
                op_a = t_reg;
                op_b = DATA_W'(cross_gain);
            end
            default:
            begin
                op_a = fx_reg;
                op_b = fx_reg;
            end
        endcase
        mul_ctl.dst  = cmd.mul_dst;
        mul_ctl.post = intmode && (cmd.mul_dst == DST_T || cmd.mul_dst == DST_TG);
        if (intmode)
            mul_ctl.sh = SH_NONE;
        else if (cmd.mul_dst == DST_TG)
            mul_ctl.sh = SH_GAIN;
        else
            mul_ctl.sh = SH_FRAC;
    end

    etfi_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (cmd.mul_issue),
        .op_a      (op_a),
        .op_b      (op_b),
        .ctl_in    (mul_ctl),
        .res_valid (res_valid),
        .res_dst   (res_dst),
        .res       (res)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg  <= DATA_W'(a_load);
            b_reg  <= DATA_W'(b_load);
            fx_reg <= DATA_W'(a_load);
            fy_reg <= DATA_W'(b_load);
            fd_reg <= '0;
        end
        if (res_valid)
        begin
            case (res_dst)
                DST_X2:  x2_reg <= res;
                DST_Y2:  y2_reg <= res;
                DST_T:   t_reg  <= res;
                DST_TG:  tg_reg <= res;
                default: t_reg  <= res;
            endcase
        end
        if (cmd.diff)
        begin
            diff_reg <= EXT_W'(x2_reg) - EXT_W'(y2_reg);
            sum_reg  <= sat_ext(EXT_W'(x2_reg) + EXT_W'(y2_reg));
        end
        if (cmd.fx_prep)
        begin
            // The integer mode saturates and rescales the difference before adding c.
            ein_reg <= intmode ? EXT_W'(tz_frac(sat_ext(diff_reg))) : diff_reg;
            fd_reg  <= intmode ? tz_frac(sum_reg) : sum_reg;
        end
        if (cmd.fx_write)
            fx_reg <= sat_ext(ein_reg + (cmd.add_c ? EXT_W'(a_reg) : EXT_W'(0)));
        if (cmd.fy_write)
            fy_reg <= sat_ext(EXT_W'(tg_reg) + (cmd.add_c ? EXT_W'(b_reg) : EXT_W'(0)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.load)
            count_reg <= '0;
        else if (cmd.count_inc)
            count_reg <= count_reg + CNT_W'(1);
    end

    assign status.go       = (count_reg < lim) && (fd_reg < bail);
    assign iteration_count = count_reg;

endmodule

FILE: src/etfi_ctrl.sv
// ----------------------------------------------------------------------------
// etfi_ctrl: controller of the escape-time fractal iterator
// Accepts a point, sequences the fixed schedule of one count step (two
// squaring passes in the quartic mode) and raises done when the loop ends.
// ----------------------------------------------------------------------------
module etfi_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    output logic                        done,
    input  logic [etfi_pkg::MODE_W-1:0] mode,
    input  etfi_pkg::status_t           status,
    output etfi_pkg::cmd_t              cmd
);
    import etfi_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_STEP
    } state_t;

    // Phases of one squaring pass; each multiplier result is written to its
    // destination register before the phase that reads it.
    localparam int PH_W = 4;
    localparam logic [PH_W-1:0] PH_SQ_X = 4'd0;
    localparam logic [PH_W-1:0] PH_SQ_Y = 4'd1;
    localparam logic [PH_W-1:0] PH_XY   = 4'd2;
    localparam logic [PH_W-1:0] PH_DIFF = 4'd5;
    localparam logic [PH_W-1:0] PH_TG   = 4'd6;
    localparam logic [PH_W-1:0] PH_FX   = 4'd7;
    localparam logic [PH_W-1:0] PH_FY   = 4'd10;

    state_t          state_reg;
    logic [PH_W-1:0] phase_reg;
    logic            half_reg;
    logic            done_reg;
    logic            last_half;

    assign last_half = (mode != MODE_QUARTIC) || half_reg;

    always_comb
    begin
        cmd           = '0;
        cmd.mul_dst   = DST_X2;
        cmd.add_c     = last_half;
        cmd.load      = (state_reg == S_IDLE) && start;
        if (state_reg == S_STEP)
        begin
            case (phase_reg)
                PH_SQ_X:
                begin
                    cmd.mul_issue = 1'b1;
                    cmd.mul_dst   = DST_X2;
                end
                PH_SQ_Y:
                begin
                    cmd.mul_issue = 1'b1;
                    cmd.mul_dst   = DST_Y2;
                end
                PH_XY:
                begin
                    cmd.mul_issue = 1'b1;
                    cmd.mul_dst   = DST_T;
                end
                PH_DIFF:
                begin
                    cmd.diff = 1'b1;
                end
                PH_TG:
                begin
                    cmd.mul_issue = 1'b1;
                    cmd.mul_dst   = DST_TG;
                    cmd.fx_prep   = 1'b1;
                end
                PH_FX:
                begin
                    cmd.fx_write = 1'b1;
                end
                PH_FY:
                begin
                    cmd.fy_write  = 1'b1;
                    cmd.count_inc = last_half;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= '0;
            half_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                        state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (status.go)
                    begin
                        state_reg <= S_STEP;
                        phase_reg <= PH_SQ_X;
                        half_reg  <= 1'b0;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                S_STEP:
                begin
                    if (phase_reg == PH_FY)
                    begin
                        phase_reg <= PH_SQ_X;
                        if (last_half)
                            state_reg <= S_CHECK;
                        else
                            half_reg <= 1'b1;
                    end
                    else
                    begin
                        phase_reg <= phase_reg + PH_W'(1);
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

FILE: src/escape_time_fractal_iterator.sv
// ----------------------------------------------------------------------------
// escape_time_fractal_iterator: escape-time count for one complex point
// Command-style block: a point goes in, one iteration count comes out.
// ----------------------------------------------------------------------------
// A word is accepted at a rising edge with start high and busy low; c_real
// and c_imag are sampled there. The result appears on iteration_count for
// exactly one cycle with done high, and the receiver must take it then.
// busy drops in the done cycle, so the next word may be started at once.
// One count step is one pass per squaring through the single multiplier
// (two squares, a cross product and a gain product per pass), then a test
// of the loop; the quartic mode makes two passes per step. busy stays high
// until the count is delivered, so a new word is taken only after the last
// one is done.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// is always ready; the user must see that it is written only while the
// block is idle, which the block itself does not enforce. Writes to an
// index past the last register are dropped. Reset returns the block to
// idle with mode 0, a count limit of 1024 and a cross gain of 2.0.
// ----------------------------------------------------------------------------
module escape_time_fractal_iterator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [etfi_pkg::IN_W-1:0]  c_real,
    input  logic signed [etfi_pkg::IN_W-1:0]  c_imag,
    output logic                              done,
    output logic [etfi_pkg::CNT_W-1:0]        iteration_count,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [etfi_pkg::IDX_W-1:0]        cfg_index,
    input  logic [etfi_pkg::CFG_W-1:0]        cfg_data
);
    import etfi_pkg::*;

    logic [MODE_W-1:0] mode_reg;
    logic [CNT_W-1:0]  maxit_reg;
    logic [GAIN_W-1:0] gain_reg;
    cmd_t              cmd;
    status_t           status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_RESET;
            maxit_reg <= MAXIT_RESET;
            gain_reg  <= GAIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MODE:  mode_reg  <= cfg_data[MODE_W-1:0];
                REG_MAXIT: maxit_reg <= cfg_data[CNT_W-1:0];
                REG_GAIN:  gain_reg  <= cfg_data[GAIN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    etfi_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .mode   (mode_reg),
        .status (status),
        .cmd    (cmd)
    );

    etfi_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .mode            (mode_reg),
        .max_iterations  (maxit_reg),
        .cross_gain      (gain_reg),
        .c_real          (c_real),
        .c_imag          (c_imag),
        .iteration_count (iteration_count)
    );

endmodule

FILE: src/etfi_checker.sv
// ----------------------------------------------------------------------------
// etfi_checker: port-level checks for the escape-time fractal iterator
// Relates start, busy and done over time; bound to the top level below.
// ----------------------------------------------------------------------------
module etfi_checker (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  logic done
);

    // An accepted word always occupies the block in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("block not busy after an accepted word");

    // The block only goes idle by delivering its result.
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result strobe outside the end of a job");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

endmodule

bind escape_time_fractal_iterator etfi_checker u_etfi_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

FILE: test/escape_time_fractal_iterator_test.sv
// ----------------------------------------------------------------------------
// escape_time_fractal_iterator_test: self-checking bench for the iterator
// Sends complex points through the start/busy command port and checks every
// iteration count against a fixed-point model of the three iteration modes,
// under a range of mode, count limit and cross gain settings.
// ----------------------------------------------------------------------------
module escape_time_fractal_iterator_test;

    timeunit 1ns;
    timeprecision 1ps;

    import etfi_pkg::*;

    localparam int     COORD_SPAN = 41943040;  // 2.5 with 24 fraction bits
    localparam longint HALF_Q24   = longint'(1) << (FRAC_BITS - 1);

    // Index that maps to no register.
    localparam logic [IDX_W-1:0] REG_NONE = 2'd3;

    typedef struct {
        logic signed [IN_W-1:0] re;
        logic signed [IN_W-1:0] im;
        logic [MODE_W-1:0]      mode;
        logic [CNT_W-1:0]       count;
    } count_due_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic signed [IN_W-1:0] c_real = '0;
    logic signed [IN_W-1:0] c_imag = '0;
    logic                   done;
    logic [CNT_W-1:0]       iteration_count;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [IDX_W-1:0]       cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;

    // Shadow copy of the block's registers.
    logic [MODE_W-1:0] mode_reg  = MODE_RESET;
    logic [CNT_W-1:0]  limit_reg = MAXIT_RESET;
    logic [GAIN_W-1:0] gain_reg  = GAIN_RESET;

    count_due_t counts_due[$];
    int         mismatch_count = 0;
    int         points_sent = 0;
    int         cfg_writes = 0;

    escape_time_fractal_iterator u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .c_real          (c_real),
        .c_imag          (c_imag),
        .done            (done),
        .iteration_count (iteration_count),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        #100_000_000;
        $display("escape_time_fractal_iterator verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Fixed-point arithmetic of the iteration
    // ------------------------------------------------------------------
    function automatic longint clamp48(longint v);
        if (v > longint'(SAT_MAX))
            return longint'(SAT_MAX);
        if (v < longint'(SAT_MIN))
            return longint'(SAT_MIN);
        return v;
    endfunction

    function automatic longint shift_toward_zero(longint v, int sh);
        if (v < 0)
            return -((-v) >>> sh);
        return v >>> sh;
    endfunction

    // Exact product, scaled down toward zero, clamped to 48 bits.
    function automatic longint scaled_product(longint a, longint b, int sh);
        bit           neg;
        logic [127:0] ua;
        logic [127:0] ub;
        logic [127:0] p;
        logic [127:0] lim;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? -a : a;
        ub  = (b < 0) ? -b : b;
        p   = (ua * ub) >> sh;
        lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 128'd1);
        if (p > lim)
            p = lim;
        if (neg)
            return -longint'(p[63:0]);
        return longint'(p[63:0]);
    endfunction

    function automatic logic [CNT_W-1:0] escape_count(logic signed [IN_W-1:0] re,
                                                      logic signed [IN_W-1:0] im);
        longint      cr;
        longint      ci;
        longint      g;
        longint      a;
        longint      b;
        longint      fx;
        longint      fy;
        longint      fd;
        longint      x2;
        longint      y2;
        longint      t;
        int unsigned lim;
        int unsigned n;
        cr  = re;
        ci  = im;
        g   = longint'(gain_reg);
        lim = (limit_reg > ITER_LIMIT) ? ITER_LIMIT : limit_reg;
        n   = 0;
        fd  = 0;
        case (mode_reg)
            MODE_QUARTIC:
            begin
                a  = cr;
                b  = ci;
                fx = a;
                fy = b;
                while (n < lim && fd < longint'(BAIL_QUARTIC))
                begin
                    x2 = scaled_product(fx, fx, FRAC_BITS);
                    y2 = scaled_product(fy, fy, FRAC_BITS);
                    t  = scaled_product(fx, fy, FRAC_BITS);
                    fy = scaled_product(t, g, GAIN_FRAC);
                    fx = clamp48(x2 - y2);
                    x2 = scaled_product(fx, fx, FRAC_BITS);
                    y2 = scaled_product(fy, fy, FRAC_BITS);
                    t  = scaled_product(fx, fy, FRAC_BITS);
                    fy = clamp48(scaled_product(t, g, GAIN_FRAC) + b);
                    fx = clamp48(x2 - y2 + a);
                    fd = clamp48(x2 + y2);
                    n++;
                end
            end
            MODE_INT:
            begin
                a  = shift_toward_zero(cr - HALF_Q24, FRAC_BITS - INT_FRAC);
                b  = shift_toward_zero(ci, FRAC_BITS - INT_FRAC);
                fx = a;
                fy = b;
                while (n < lim && fd < longint'(BAIL_INT))
                begin
                    x2 = scaled_product(fx, fx, 0);
                    y2 = scaled_product(fy, fy, 0);
                    t  = shift_toward_zero(scaled_product(fx, fy, 0), INT_FRAC);
                    t  = shift_toward_zero(scaled_product(t, g, 0), GAIN_FRAC);
                    fy = clamp48(t + b);
                    fx = clamp48(shift_toward_zero(clamp48(x2 - y2), INT_FRAC) + a);
                    fd = shift_toward_zero(clamp48(x2 + y2), INT_FRAC);
                    n++;
                end
            end
            default:
            begin
                // The unused mode code runs the plain quadratic iteration.
                a  = cr - HALF_Q24;
                b  = ci;
                fx = a;
                fy = b;
                while (n < lim && fd < longint'(BAIL_QUAD))
                begin
                    x2 = scaled_product(fx, fx, FRAC_BITS);
                    y2 = scaled_product(fy, fy, FRAC_BITS);
                    t  = scaled_product(fx, fy, FRAC_BITS);
                    fy = clamp48(scaled_product(t, g, GAIN_FRAC) + b);
                    fx = clamp48(x2 - y2 + a);
                    fd = clamp48(x2 + y2);
                    n++;
                end
            end
        endcase
        return n[CNT_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        count_due_t due;
        if (rst_n && done !== 1'b0)
        begin
            if (counts_due.size() == 0)
            begin
                report_mismatch($sformatf("count %0d with no point pending", iteration_count));
            end
            else
            begin
                due = counts_due.pop_front();
                if (iteration_count !== due.count)
                    report_mismatch($sformatf("mode %0d c=(%h,%h): count %0d, want %0d",
                                              due.mode, due.re, due.im,
                                              iteration_count, due.count));
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Offers one point, waits until the block takes the word, then maybe idles.
    task automatic send_point(input logic signed [IN_W-1:0] re,
                              input logic signed [IN_W-1:0] im,
                              input int idle_pct);
        count_due_t due;
        start  <= 1'b1;
        c_real <= re;
        c_imag <= im;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        due.re    = re;
        due.im    = im;
        due.mode  = mode_reg;
        due.count = escape_count(re, im);
        counts_due.insert(counts_due.size(), due);
        points_sent++;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 300 : 40))
                @(posedge clk);
        end
    endtask

    task automatic wait_for_counts();
        start <= 1'b0;
        while (counts_due.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        case (idx)
            REG_MODE:  mode_reg  = data[MODE_W-1:0];
            REG_MAXIT: limit_reg = data[CNT_W-1:0];
            REG_GAIN:  gain_reg  = data[GAIN_W-1:0];
            default:   ;
        endcase
        cfg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] mode_word,
                              input logic [CFG_W-1:0] limit_word,
                              input logic [CFG_W-1:0] gain_word);
        write_register(REG_MODE, mode_word);
        write_register(REG_MAXIT, limit_word);
        write_register(REG_GAIN, gain_word);
    endtask

    function automatic logic signed [IN_W-1:0] draw_coordinate();
        int sel;
        int v;
        sel = $urandom_range(99);
        if (sel < 70)
            v = int'($urandom_range(0, 2 * COORD_SPAN)) - COORD_SPAN;
        else if (sel < 85)
            v = int'($urandom_range(0, 1 << 21)) - (1 << 20);
        else
            v = $urandom;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_defaults();
        // Registers as left by reset: quadratic, limit 1024, gain 2.0.
        send_point(32'sd0, 32'sd0, 0);
        send_point(32'sh7fffffff, 32'sh7fffffff, 0);
        send_point(32'sh80000000, 32'sh80000000, 0);
        send_point(32'sh80000000, 32'sh7fffffff, 0);
        wait_for_counts();
    endtask

    task automatic test_quartic_mode();
        set_config(CFG_W'(MODE_QUARTIC), 16'd64, GAIN_RESET);
        send_point(32'sd0, 32'sd0, 0);
        send_point(32'sh7fffffff, 32'sh80000000, 0);
        send_point(32'sh80000000, 32'sh80000000, 0);
        send_point(32'sh004ccccd, 32'sh00800000, 0);
        wait_for_counts();
    endtask

    task automatic test_integer_mode();
        set_config(CFG_W'(MODE_INT), 16'd64, GAIN_RESET);
        send_point(32'sd0, 32'sd0, 0);
        // Small negative parts exercise truncation toward zero.
        send_point(-32'sd12345, -32'sd777, 0);
        send_point(32'sh80000000, 32'sh7fffffff, 0);
        send_point(32'sh01000000, 32'sd0, 0);
        wait_for_counts();
    endtask

    task automatic test_unused_mode();
        // Upper data bits are dropped, leaving the unused mode code.
        set_config(16'hffff, 16'd50, GAIN_RESET);
        send_point(32'sd0, 32'sd0, 0);
        send_point(32'sh00c00000, 32'sh00400000, 0);
        wait_for_counts();
    endtask

    task automatic test_count_limits();
        set_config(CFG_W'(MODE_QUAD), 16'd0, GAIN_RESET);
        send_point(32'sd0, 32'sd0, 0);
        wait_for_counts();
        write_register(REG_MAXIT, 16'd1);
        send_point(32'sd0, 32'sd0, 0);
        wait_for_counts();
        write_register(REG_MAXIT, 16'h8007);
        send_point(32'sd0, 32'sd0, 0);
        wait_for_counts();
        write_register(REG_MAXIT, CFG_W'(ITER_LIMIT));
        send_point(32'sd0, 32'sd0, 0);
        wait_for_counts();
        // A limit above the ceiling is clamped to it.
        write_register(REG_MAXIT, 16'h7fff);
        send_point(32'sd0, 32'sd0, 0);
        wait_for_counts();
    endtask

    task automatic test_cross_gain();
        set_config(CFG_W'(MODE_QUAD), 16'd40, 16'd0);
        send_point(32'sh0019999a, 32'sh00e66666, 0);
        wait_for_counts();
        write_register(REG_GAIN, 16'hffff);
        send_point(32'sh0019999a, 32'sh00333333, 0);
        wait_for_counts();
        write_register(REG_GAIN, 16'd1024);
        send_point(32'sh00400000, 32'sh00800000, 0);
        wait_for_counts();
        write_register(REG_MODE, CFG_W'(MODE_QUARTIC));
        write_register(REG_GAIN, 16'hffff);
        send_point(32'sd0, 32'sh00028f5c, 0);
        wait_for_counts();
    endtask

    task automatic test_register_index();
        // A write past the last register must leave the settings alone.
        set_config(CFG_W'(MODE_QUAD), 16'd30, GAIN_RESET);
        write_register(REG_NONE, 16'hffff);
        send_point(32'sd0, 32'sd0, 0);
        wait_for_counts();
    endtask

    task automatic test_random_points();
        int idle_pcts[3];
        int limit;
        int gain;
        idle_pcts = '{0, 59, 26};
        foreach (idle_pcts[p])
        begin
            for (int seg = 0; seg < 6; seg++)
            begin
                limit = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 24);
                case ($urandom_range(3))
                    0, 1:    gain = int'(GAIN_RESET);
                    2:       gain = $urandom_range(1024, 3072);
                    default: gain = $urandom_range(0, 65535);
                endcase
                set_config(CFG_W'($urandom_range(0, 3)), CFG_W'(limit), CFG_W'(gain));
                for (int k = 0; k < 32; k++)
                begin
                    // Hold off once per setting until the block has drained.
                    if (k == 16)
                        wait_for_counts();
                    send_point(draw_coordinate(), draw_coordinate(), idle_pcts[p]);
                end
                wait_for_counts();
            end
        end
    endtask

    initial
    begin
        int spin;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_quartic_mode();
        test_integer_mode();
        test_unused_mode();
        test_count_limits();
        test_cross_gain();
        test_register_index();
        test_random_points();

        start <= 1'b0;
        spin = 0;
        while (counts_due.size() != 0 && spin < 400000)
        begin
            @(posedge clk);
            spin++;
        end
        repeat (64) @(posedge clk);
        if (counts_due.size() != 0)
            report_mismatch($sformatf("%0d counts never arrived", counts_due.size()));

        $display("Sent %0d points through all four mode codes with %0d register writes.",
                 points_sent, cfg_writes);
        $display("Limits ranged from zero to above the ceiling, cross gain from 0 to full scale.");
        if (mismatch_count == 0)
            $display("escape_time_fractal_iterator verification clean");
        else
            $display("escape_time_fractal_iterator verification failed");
        $finish;
    end

endmodule

FILE: files.f
src/etfi_pkg.sv
src/etfi_mul.sv
src/etfi_datapath.sv
src/etfi_ctrl.sv
src/escape_time_fractal_iterator.sv
src/etfi_checker.sv
test/escape_time_fractal_iterator_test.sv
